// ===== rtl/npcs_pkg.sv =====
package npcs_pkg;

	// Default palette depth.
	localparam int PALETTE_ENTRIES_DEF = 256;

	// Width of one squared distance: 3 * 255 * 255 fits in 18 bits.
	localparam int DIST_W = 18;

	// Starting best distance, larger than any real distance.
	localparam logic [DIST_W-1:0] DIST_INIT = '1;

	// Request function codes.
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// One palette color, red in the top byte.
	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} color_t;

	// Tag that travels with one entry through the scan pipeline.
	typedef struct packed {
		logic       vld;
		logic       last;
		logic [7:0] idx;
	} scan_tag_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

endpackage

// ===== rtl/npcs_palette.sv =====
module npcs_palette
	import npcs_pkg::*;
#(
	parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF,
	parameter int IDX_W           = $clog2(PALETTE_ENTRIES)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  color_t           wr_data,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output color_t           rd_data
);

	color_t               mem [PALETTE_ENTRIES];
	color_t               rd_data_q;
	logic                 rd_vld_q;
	logic [PALETTE_ENTRIES-1:0] vld_q;

	// Palette storage with a registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Written-entry flags; an entry never written reads as black.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== rtl/npcs_dist.sv =====
module npcs_dist
	import npcs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  color_t            tgt,
	input  color_t            ent,
	input  scan_tag_t         tag_in,
	output logic [DIST_W-1:0] sq_sum,
	output scan_tag_t         tag_out
);

	logic [7:0]  dr, dg, db;
	logic [15:0] sq_r_s2, sq_g_s2, sq_b_s2;
	scan_tag_t   tag_s2;

	// Absolute channel differences.
	assign dr = (ent.r >= tgt.r) ? (ent.r - tgt.r) : (tgt.r - ent.r);
	assign dg = (ent.g >= tgt.g) ? (ent.g - tgt.g) : (tgt.g - ent.g);
	assign db = (ent.b >= tgt.b) ? (ent.b - tgt.b) : (tgt.b - ent.b);

	// Squares are registered before the sum.
	always_ff @(posedge clk) begin
		sq_r_s2 <= 16'(dr) * 16'(dr);
		sq_g_s2 <= 16'(dg) * 16'(dg);
		sq_b_s2 <= 16'(db) * 16'(db);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else begin
			tag_s2 <= tag_in;
		end
	end

	// Sum of the three squares goes straight to the compare.
	assign sq_sum  = DIST_W'(sq_r_s2) + DIST_W'(sq_g_s2) + DIST_W'(sq_b_s2);
	assign tag_out = tag_s2;

endmodule

// ===== rtl/npcs_seq.sv =====
module npcs_seq
	import npcs_pkg::*;
#(
	parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF,
	parameter int IDX_W           = $clog2(PALETTE_ENTRIES)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              func,
	input  logic [7:0]        entry_index,
	input  color_t            in_color,
	output logic              wr_en,
	output logic              rd_en,
	output logic [IDX_W-1:0]  rd_addr,
	output color_t            tgt,
	output scan_tag_t         tag_s1,
	input  logic [DIST_W-1:0] sq_sum,
	input  scan_tag_t         dist_tag,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        best_index
);

	localparam logic [7:0] LAST_IDX = 8'(PALETTE_ENTRIES - 1);

	state_t            state_q;
	logic [7:0]        cnt_q;
	color_t            tgt_q;
	logic [DIST_W-1:0] best_dist_q;
	logic [7:0]        best_idx_q;
	logic              out_valid_q;
	logic              accept;
	logic              issue_last;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign wr_en      = accept && (func == FUNC_WRITE)
	                    && ({1'b0, entry_index} < 9'(PALETTE_ENTRIES));
	assign rd_en      = (state_q == ST_SCAN);
	assign rd_addr    = cnt_q[IDX_W-1:0];
	assign issue_last = (cnt_q == LAST_IDX);
	assign tgt        = tgt_q;
	assign out_valid  = out_valid_q;
	assign best_index = best_idx_q;

	// Target color is held for the whole scan.
	always_ff @(posedge clk) begin
		if (accept && (func == FUNC_QUERY)) begin
			tgt_q <= in_color;
		end
	end

	// Scan sequencer and running minimum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			best_dist_q <= DIST_INIT;
			best_idx_q  <= 8'd1;
			out_valid_q <= 1'b0;
			tag_s1      <= '0;
		end else begin
			tag_s1 <= '0;
			if (dist_tag.vld && (sq_sum < best_dist_q)) begin
				best_dist_q <= sq_sum;
				best_idx_q  <= dist_tag.idx;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (func == FUNC_QUERY)) begin
						cnt_q       <= 8'd1;
						best_dist_q <= DIST_INIT;
						best_idx_q  <= 8'd1;
						state_q     <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					tag_s1 <= '{vld: 1'b1, last: issue_last, idx: cnt_q};
					cnt_q  <= cnt_q + 8'd1;
					if (issue_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (dist_tag.vld && dist_tag.last) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q     <= ST_IDLE;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

	// A new request is never taken while a result waits.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("request accepted while result pending");

	// Distances only arrive during a scan or its drain.
	assert property (@(posedge clk) disable iff (!arst_n)
		dist_tag.vld |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
		else $error("distance outside of a scan");

	// The result never points at the transparent entry or past the palette.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (best_idx_q != 8'd0 && best_idx_q <= LAST_IDX))
		else $error("best index out of range");

	// A result appears only after the last entry has been compared.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(dist_tag.vld && dist_tag.last))
		else $error("result before scan completed");

endmodule

// ===== rtl/nearest_palette_color_search.sv =====
// Palette write: accepted with no result; one write per cycle while idle.
// Query: the result is set by a scan of one entry per cycle through the single
// palette read port and distance unit.
// A new request is taken the cycle after the result is accepted.
// Reset (arst_n low) clears all written-entry flags, so every entry reads as black.
module nearest_palette_color_search
	import npcs_pkg::*;
#(
	parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       func,
	input  logic [7:0] entry_index,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] best_index
);

	localparam int IDX_W = $clog2(PALETTE_ENTRIES);

	color_t            in_color;
	color_t            rd_data;
	color_t            tgt;
	logic              wr_en;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	scan_tag_t         tag_s1;
	scan_tag_t         dist_tag;
	logic [DIST_W-1:0] sq_sum;

	assign in_color = '{r: red, g: green, b: blue};

	npcs_palette #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES),
		.IDX_W          (IDX_W)
	) u_palette (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (wr_en),
		.wr_addr(entry_index[IDX_W-1:0]),
		.wr_data(in_color),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	npcs_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.tgt    (tgt),
		.ent    (rd_data),
		.tag_in (tag_s1),
		.sq_sum (sq_sum),
		.tag_out(dist_tag)
	);

	npcs_seq #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES),
		.IDX_W          (IDX_W)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.entry_index(entry_index),
		.in_color   (in_color),
		.wr_en      (wr_en),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.tgt        (tgt),
		.tag_s1     (tag_s1),
		.sq_sum     (sq_sum),
		.dist_tag   (dist_tag),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.best_index (best_index)
	);

endmodule

// ===== tb/nearest_palette_color_search_tb.sv =====
module nearest_palette_color_search_tb;
	import npcs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PALETTE_SIZE = PALETTE_ENTRIES_DEF;
	localparam int DIST_START = 32'h7FFF_FFFF;
	localparam int RANDOM_ITEMS = 1400;
	localparam int SEGMENT_ITEMS = 64;
	localparam int CALM_TAIL = 200;
	localparam int DRAIN_CYCLES = 300;

	// Palette shadow and queue of expected nearest indexes.
	class palette_scoreboard;
		color_t palette [PALETTE_SIZE];
		logic [7:0] expected_index [$];
		int n_writes;
		int n_queries;
		int n_checked;
		int n_errors;

		function new();
			foreach (palette[i])
				palette[i] = '0;
			n_writes = 0;
			n_queries = 0;
			n_checked = 0;
			n_errors = 0;
		endfunction

		// Scan entries 1 and up; a strictly smaller distance is needed to move,
		// so the lowest index wins a tie.
		function logic [7:0] nearest(color_t target);
			int best_dist;
			int sq_sum;
			int dr;
			int dg;
			int db;
			logic [7:0] best;
			best_dist = DIST_START;
			best = 8'd1;
			for (int i = 1; i < PALETTE_SIZE; i++) begin
				dr = int'(palette[i].r) - int'(target.r);
				dg = int'(palette[i].g) - int'(target.g);
				db = int'(palette[i].b) - int'(target.b);
				sq_sum = dr * dr + dg * dg + db * db;
				if (sq_sum < best_dist) begin
					best_dist = sq_sum;
					best = i[7:0];
				end
			end
			return best;
		endfunction

		// An accepted write updates the shadow; an accepted query expects one result.
		function void note_request(logic f, logic [7:0] idx, color_t c);
			if (f == FUNC_WRITE) begin
				n_writes++;
				if (int'(idx) < PALETTE_SIZE)
					palette[idx] = c;
			end else begin
				n_queries++;
				expected_index.push_back(nearest(c));
			end
		endfunction

		function void check_result(logic [7:0] got);
			logic [7:0] want;
			if (expected_index.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected result, expected none, actual best_index=%0d",
					$time, got);
			end else begin
				want = expected_index.pop_front();
				n_checked++;
				if (got !== want) begin
					n_errors++;
					$display("%0t: best_index mismatch, expected %0d, actual %0d",
						$time, want, got);
				end
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       func = FUNC_WRITE;
	logic [7:0] entry_index = '0;
	logic [7:0] red = '0;
	logic [7:0] green = '0;
	logic [7:0] blue = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] best_index;

	palette_scoreboard sb;
	int idle_pct = 20;
	bit pool_mode = 1'b0;
	color_t color_pool [4];

	nearest_palette_color_search u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.entry_index (entry_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.best_index  (best_index)
	);

	always #2 clk = ~clk;

	// Watch both handshakes with the values held just before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_request(func, entry_index, color_t'({red, green, blue}));
			if (out_valid && out_ready)
				sb.check_result(best_index);
		end
	end

	// Result side: random stalls of out_ready while idling is enabled.
	initial begin
		int stall_left;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
				out_ready <= 1'b0;
				stall_left = $urandom_range(0, 2);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Present one request, after an optional gap, and hold it until it is taken.
	task automatic send_request(logic f, logic [7:0] idx, color_t c);
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		entry_index <= idx;
		red <= c.r;
		green <= c.g;
		blue <= c.b;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	function automatic logic [7:0] random_channel();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 12)
			return 8'd0;
		if (pick < 24)
			return 8'd255;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic color_t random_color();
		if (pool_mode)
			return color_pool[$urandom_range(0, 3)];
		return color_t'({random_channel(), random_channel(), random_channel()});
	endfunction

	function automatic logic [7:0] nudge(logic [7:0] v);
		int x;
		x = int'(v) + $urandom_range(0, 8) - 4;
		if (x < 0)
			x = 0;
		if (x > 255)
			x = 255;
		return x[7:0];
	endfunction

	// Mostly writes; queries either random, on a stored color, or close to one.
	task automatic random_request();
		int pick;
		color_t c;
		color_t e;
		logic [7:0] idx;
		pick = $urandom_range(0, 99);
		e = sb.palette[$urandom_range(1, PALETTE_SIZE - 1)];
		if (pick < 12) begin
			pick = $urandom_range(0, 99);
			if (pick < 35)
				c = random_color();
			else if (pick < 70)
				c = e;
			else
				c = color_t'({nudge(e.r), nudge(e.g), nudge(e.b)});
			send_request(FUNC_QUERY, 8'($urandom_range(0, 255)), c);
		end else begin
			idx = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 19) == 0)
				idx = 8'd0;
			if ($urandom_range(0, 6) == 0)
				c = e;
			else
				c = random_color();
			send_request(FUNC_WRITE, idx, c);
		end
	endtask

	initial begin
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: an all-black palette answers with entry 1.
		send_request(FUNC_QUERY, 8'd0, color_t'(24'h000000));
		send_request(FUNC_QUERY, 8'd255, color_t'(24'hFFFFFF));
		// Entry zero is stored but never chosen.
		send_request(FUNC_WRITE, 8'd0, color_t'({8'd200, 8'd100, 8'd50}));
		send_request(FUNC_QUERY, 8'd0, color_t'({8'd200, 8'd100, 8'd50}));
		// Top entry and the extremes of every channel.
		send_request(FUNC_WRITE, 8'd255, color_t'(24'hFFFFFF));
		send_request(FUNC_QUERY, 8'd0, color_t'(24'hFFFFFF));
		send_request(FUNC_QUERY, 8'd0, color_t'({8'd250, 8'd250, 8'd250}));
		// Exact tie between entries 128 and 255 goes to the lower index.
		send_request(FUNC_WRITE, 8'd128, color_t'(24'hFFFFFF));
		send_request(FUNC_QUERY, 8'd0, color_t'(24'hFFFFFF));
		send_request(FUNC_WRITE, 8'd1, color_t'(24'hFF0000));
		send_request(FUNC_QUERY, 8'd0, color_t'(24'hFF0000));
		send_request(FUNC_WRITE, 8'd254, color_t'(24'h0000FF));
		send_request(FUNC_QUERY, 8'd0, color_t'(24'h0000FF));
		send_request(FUNC_WRITE, 8'd127, color_t'(24'h00FF00));
		send_request(FUNC_QUERY, 8'd0, color_t'(24'h00FF00));
		// Equal nonzero distance from two entries.
		send_request(FUNC_WRITE, 8'd2, color_t'({8'd10, 8'd10, 8'd10}));
		send_request(FUNC_WRITE, 8'd3, color_t'({8'd12, 8'd12, 8'd12}));
		send_request(FUNC_QUERY, 8'd0, color_t'({8'd11, 8'd11, 8'd11}));
		// Overwrite entry 1 and check that black still maps to an unwritten entry.
		send_request(FUNC_WRITE, 8'd1, color_t'(24'h808080));
		send_request(FUNC_QUERY, 8'd0, color_t'(24'h000000));

		// Random part in segments with their own idling and color choice.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % SEGMENT_ITEMS == 0) begin
				pool_mode = ($urandom_range(0, 2) == 0);
				foreach (color_pool[k])
					color_pool[k] = color_t'({random_channel(), random_channel(),
						random_channel()});
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 15;
					default: idle_pct = 35;
				endcase
			end
			if (i >= RANDOM_ITEMS - CALM_TAIL)
				idle_pct = 0;
			random_request();
		end
		in_valid <= 1'b0;

		// Let outstanding results drain, then watch for anything stray.
		while (sb.expected_index.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d palette writes and %0d nearest-color queries.",
			sb.n_writes, sb.n_queries);
		$display("%0d results checked, %0d mismatches.", sb.n_checked, sb.n_errors);
		if (sb.n_errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Safety net against a hung handshake.
	initial begin
		#6_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
